// ===== rtl/gsa_pkg.sv =====
package gsa_pkg;

	// field widths
	localparam int SLOT_W   = 14;
	localparam int CNT_W    = SLOT_W + 1;
	localparam int GEN_W    = 32;
	localparam int HANDLE_W = 46;
	localparam int SLOTS    = 1 << SLOT_W;

	// free head value for an empty free list
	localparam logic [CNT_W-1:0] EMPTY_MARK = CNT_W'(SLOTS);

	typedef enum logic [1:0] {
		REQ_ALLOC  = 2'd0,
		REQ_FREE   = 2'd1,
		REQ_HANDLE = 2'd2,
		REQ_LOOKUP = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_RANGE = 3'd2,
		ST_FREE  = 3'd3,
		ST_STALE = 3'd4
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_EXEC
	} fsm_t;

	// one slot memory word
	typedef struct packed {
		logic [SLOT_W-1:0] next;
		logic              is_free;
		logic [GEN_W-1:0]  gen;
	} entry_t;

	// allocator registers
	typedef struct packed {
		logic [CNT_W-1:0] free_head;
		logic [CNT_W-1:0] high_water;
		logic [GEN_W-1:0] gen_counter;
		logic [CNT_W-1:0] live_count;
	} alloc_state_t;

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		logic [HANDLE_W-1:0] handle;
		logic [CNT_W-1:0]    live;
	} result_t;

	// what one request does to memory, registers and output
	typedef struct packed {
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		entry_t            wr_entry;
		alloc_state_t      next_state;
		result_t           result;
	} update_t;

endpackage

// ===== rtl/gsa_decide.sv =====
module gsa_decide (
	input  gsa_pkg::req_t                      req,
	input  logic [gsa_pkg::SLOT_W-1:0]         slot_index,
	input  logic [gsa_pkg::HANDLE_W-1:0]       handle,
	input  gsa_pkg::entry_t                    entry,
	input  gsa_pkg::alloc_state_t              cur,
	output gsa_pkg::update_t                   upd
);

	logic                          from_list;
	logic                          below_top;
	logic [gsa_pkg::CNT_W-1:0]     live_inc;
	logic [gsa_pkg::SLOT_W-1:0]    alloc_slot;
	logic [gsa_pkg::GEN_W-1:0]     gen_inc;
	logic [gsa_pkg::SLOT_W-1:0]    look_slot;
	logic                          sidx_range;
	logic                          look_range;

	// shared terms
	assign from_list  = cur.live_count < cur.high_water;
	assign below_top  = cur.high_water < gsa_pkg::EMPTY_MARK;
	assign live_inc   = cur.live_count + gsa_pkg::CNT_W'(1);
	assign gen_inc    = cur.gen_counter + gsa_pkg::GEN_W'(1);
	assign alloc_slot = from_list ? cur.free_head[gsa_pkg::SLOT_W-1:0]
	                              : cur.high_water[gsa_pkg::SLOT_W-1:0];
	assign look_slot  = handle[gsa_pkg::HANDLE_W-1:gsa_pkg::GEN_W];
	assign sidx_range = {1'b0, slot_index} >= cur.high_water;
	assign look_range = {1'b0, look_slot} >= cur.high_water;

	// request decode
	always_comb begin
		upd               = '0;
		upd.wr_entry      = entry;
		upd.next_state    = cur;
		upd.result.status = gsa_pkg::ST_OK;
		unique case (req)
			gsa_pkg::REQ_ALLOC: begin
				if (from_list || below_top) begin
					upd.wr_en            = 1'b1;
					upd.wr_addr          = alloc_slot;
					upd.wr_entry.is_free = 1'b0;
					upd.wr_entry.gen     = gen_inc;
					upd.next_state.gen_counter = gen_inc;
					upd.next_state.live_count  = live_inc;
					if (from_list) begin
						upd.next_state.free_head = (live_inc < cur.high_water)
							? {1'b0, entry.next} : gsa_pkg::EMPTY_MARK;
					end else begin
						upd.next_state.high_water = cur.high_water + gsa_pkg::CNT_W'(1);
					end
					upd.result.slot   = alloc_slot;
					upd.result.handle = {alloc_slot, gen_inc};
				end else begin
					upd.result.status = gsa_pkg::ST_FULL;
				end
			end
			gsa_pkg::REQ_FREE: begin
				if (sidx_range) begin
					upd.result.status = gsa_pkg::ST_RANGE;
				end else if (entry.is_free) begin
					upd.result.status = gsa_pkg::ST_FREE;
				end else begin
					upd.wr_en            = 1'b1;
					upd.wr_addr          = slot_index;
					upd.wr_entry.next    = cur.free_head[gsa_pkg::SLOT_W-1:0];
					upd.wr_entry.is_free = 1'b1;
					upd.next_state.free_head  = {1'b0, slot_index};
					upd.next_state.live_count = cur.live_count - gsa_pkg::CNT_W'(1);
					upd.result.slot = slot_index;
				end
			end
			gsa_pkg::REQ_HANDLE: begin
				if (sidx_range) begin
					upd.result.status = gsa_pkg::ST_RANGE;
				end else begin
					upd.result.slot   = slot_index;
					upd.result.handle = {slot_index, entry.gen};
				end
			end
			gsa_pkg::REQ_LOOKUP: begin
				if (look_range) begin
					upd.result.status = gsa_pkg::ST_RANGE;
				end else if (entry.is_free) begin
					upd.result.status = gsa_pkg::ST_FREE;
				end else if (entry.gen != handle[gsa_pkg::GEN_W-1:0]) begin
					upd.result.status = gsa_pkg::ST_STALE;
				end else begin
					upd.result.slot   = look_slot;
					upd.result.handle = handle;
				end
			end
		endcase
		upd.result.live = upd.next_state.live_count;
	end

endmodule

// ===== rtl/generational_slot_allocator_unit.sv =====
// Generational slot allocator: hands out slots of a 16384-entry pool as handles
// {slot, 32-bit generation}, reuses freed slots last-in first-out and checks
// handles on lookup. A request is accepted in the idle state, where the block
// issues the read of the single slot memory (next link, free flag, generation);
// in the execute state it decides, writes the entry back and loads the output
// register. A stalled output holds the block in its execute state. All slot
// state lives in one synchronous RAM that needs no clearing pass; only slots
// below the high-water mark affect results, so it is ready right after reset.
module generational_slot_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slot_index [13:0], handle [59:14], zero [63:60]
	input  logic [63:0] s_tdata,
	// req_type [1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_slot [13:0], result_handle [59:14], live_slots [74:60], zero [79:75]
	output logic [79:0] m_tdata,
	// status [2:0]
	output logic [2:0]  m_tuser
);

	localparam int HI_HANDLE = gsa_pkg::SLOT_W + gsa_pkg::HANDLE_W;

	gsa_pkg::fsm_t                   state_q, state_d;
	gsa_pkg::alloc_state_t           regs_q;
	gsa_pkg::req_t                   req_s1;
	logic [gsa_pkg::SLOT_W-1:0]      sidx_s1;
	logic [gsa_pkg::HANDLE_W-1:0]    handle_s1;
	gsa_pkg::entry_t                 rd_entry_s1;
	gsa_pkg::entry_t                 slot_mem [gsa_pkg::SLOTS];
	gsa_pkg::update_t                upd;
	gsa_pkg::result_t                result_q;
	logic                            m_tvalid_q;
	logic                            accept;
	logic                            exec_fire;
	gsa_pkg::req_t                   in_req;
	logic [gsa_pkg::SLOT_W-1:0]      in_sidx;
	logic [gsa_pkg::HANDLE_W-1:0]    in_handle;
	logic [gsa_pkg::SLOT_W-1:0]      rd_addr;

	assign in_req    = gsa_pkg::req_t'(s_tuser);
	assign in_sidx   = s_tdata[gsa_pkg::SLOT_W-1:0];
	assign in_handle = s_tdata[HI_HANDLE-1:gsa_pkg::SLOT_W];

	// sequencer
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		exec_fire = 1'b0;
		unique case (state_q)
			gsa_pkg::FSM_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = gsa_pkg::FSM_EXEC;
			end
			gsa_pkg::FSM_EXEC: begin
				exec_fire = !m_tvalid_q || m_tready;
				if (exec_fire) state_d = gsa_pkg::FSM_IDLE;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gsa_pkg::FSM_IDLE;
		else         state_q <= state_d;
	end

	// read address: allocation looks at the list head or the high-water slot
	always_comb begin
		unique case (in_req)
			gsa_pkg::REQ_ALLOC: begin
				rd_addr = (regs_q.live_count < regs_q.high_water)
					? regs_q.free_head[gsa_pkg::SLOT_W-1:0]
					: regs_q.high_water[gsa_pkg::SLOT_W-1:0];
			end
			gsa_pkg::REQ_FREE, gsa_pkg::REQ_HANDLE: rd_addr = in_sidx;
			gsa_pkg::REQ_LOOKUP: rd_addr = in_handle[gsa_pkg::HANDLE_W-1:gsa_pkg::GEN_W];
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1    <= in_req;
			sidx_s1   <= in_sidx;
			handle_s1 <= in_handle;
		end
	end

	// slot memory, read on accept, written back when the request executes
	always_ff @(posedge clk) begin
		if (exec_fire && upd.wr_en) slot_mem[upd.wr_addr] <= upd.wr_entry;
		if (accept) rd_entry_s1 <= slot_mem[rd_addr];
	end

	gsa_decide u_decide (
		.req        (req_s1),
		.slot_index (sidx_s1),
		.handle     (handle_s1),
		.entry      (rd_entry_s1),
		.cur        (regs_q),
		.upd        (upd)
	);

	// allocator registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.free_head   <= gsa_pkg::EMPTY_MARK;
			regs_q.high_water  <= '0;
			regs_q.gen_counter <= '0;
			regs_q.live_count  <= '0;
		end else if (exec_fire) begin
			regs_q <= upd.next_state;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        m_tvalid_q <= 1'b0;
		else if (exec_fire) m_tvalid_q <= 1'b1;
		else if (m_tready)  m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (exec_fire) result_q <= upd.result;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = result_q.status;
	assign m_tdata  = {5'b0, result_q.live, result_q.handle, result_q.slot};

	// checks
	a_live_le_hw: assert property (@(posedge clk) disable iff (!arst_n)
		regs_q.live_count <= regs_q.high_water)
		else $error("live count above high-water mark");

	a_hw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		regs_q.high_water <= gsa_pkg::EMPTY_MARK)
		else $error("high-water mark beyond pool");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(regs_q.live_count == regs_q.high_water) |-> (regs_q.free_head == gsa_pkg::EMPTY_MARK))
		else $error("empty free list without empty marker");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(regs_q.live_count < regs_q.high_water) |-> (regs_q.free_head < regs_q.high_water))
		else $error("free list head outside used slots");

	a_gen_step: assert property (@(posedge clk) disable iff (!arst_n)
		(regs_q.gen_counter != $past(regs_q.gen_counter)) |->
		(regs_q.gen_counter == $past(regs_q.gen_counter) + gsa_pkg::GEN_W'(1)))
		else $error("generation counter skipped");

	a_two_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request accepted while one is in flight");

endmodule
